/* rtl/hafd_pkg.sv */
// Shared types, type codes and decode helpers for the hex ASCII field decoder.
package hafd_pkg;

  localparam logic [3:0] TYPE_U8     = 4'd0;
  localparam logic [3:0] TYPE_U16    = 4'd1;
  localparam logic [3:0] TYPE_U32    = 4'd2;
  localparam logic [3:0] TYPE_U64    = 4'd3;
  localparam logic [3:0] TYPE_S8     = 4'd4;
  localparam logic [3:0] TYPE_S16    = 4'd5;
  localparam logic [3:0] TYPE_S32    = 4'd6;
  localparam logic [3:0] TYPE_S64    = 4'd7;
  localparam logic [3:0] TYPE_F32    = 4'd8;
  localparam logic [3:0] TYPE_F64    = 4'd9;
  localparam logic [3:0] TYPE_STRING = 4'd10;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_TYPE = 1'b1;

  localparam logic [15:0] MAX_STRING_BYTES = 16'd255;

  localparam int VALUE_W = 64;
  localparam int USER_W  = 5;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [3:0]         value_type;
    logic               status;
    logic               last;
  } hafd_res_t;

  // ASCII hex digit to nibble; anything else decodes as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= "0" && c <= "9") n = 4'(c - "0");
    else if (c >= "a" && c <= "f") n = 4'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") n = 4'(c - "A" + 8'd10);
    return n;
  endfunction

  // index of the final byte of a numeric type
  function automatic logic [2:0] last_byte_idx(input logic [3:0] t);
    logic [2:0] r;
    unique case (t)
      TYPE_F32: r = 3'd3;
      TYPE_F64: r = 3'd7;
      default: begin
        case (t[1:0])
          2'd0:    r = 3'd0;
          2'd1:    r = 3'd1;
          2'd2:    r = 3'd3;
          default: r = 3'd7;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/hafd_decode.sv */
// Field state and per-character decode: builds at most one result per transaction.
module hafd_decode
  import hafd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] hex_char,
  input  logic [3:0] field_type,
  input  logic [7:0] string_length,
  output logic       res_valid,
  output hafd_res_t  res
);

  logic [8:0]         char_count_r, char_count_nxt;
  logic [3:0]         held_type_r, held_type_nxt;
  logic [7:0]         held_length_r, held_length_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic [3:0]         high_nib_r, high_nib_nxt;

  logic               start;
  logic [3:0]         nib;
  logic [3:0]         cur_type;
  logic [7:0]         cur_len;
  logic [7:0]         len_fix;
  logic [VALUE_W-1:0] acc_base;
  logic [VALUE_W-1:0] acc_new;
  logic [VALUE_W-1:0] sval;
  logic [7:0]         byte_val;
  logic [7:0]         byte_idx;
  logic               str_fin;

  assign start    = (char_count_r == 9'd0);
  assign nib      = nibble_of(hex_char);
  assign byte_val = {high_nib_r, nib};
  assign byte_idx = char_count_r[8:1];

  always_comb begin
    len_fix = (string_length == 8'd0) ? 8'd1 : string_length;
    if (16'(len_fix) > MAX_STRING_BYTES) len_fix = MAX_STRING_BYTES[7:0];
  end

  assign cur_type = start ? field_type : held_type_r;
  assign cur_len  = start ? len_fix : held_length_r;
  assign acc_base = start ? '0 : acc_r;
  assign str_fin  = (9'(byte_idx) + 9'd1 >= 9'(cur_len));

  // drop the new byte into its little-endian lane
  always_comb begin
    acc_new = acc_base;
    for (int k = 0; k < VALUE_W / 8; k++) begin
      if (byte_idx[2:0] == 3'(k)) acc_new[k*8 +: 8] = byte_val;
    end
  end

  always_comb begin
    sval = acc_new;
    case (held_type_r)
      TYPE_S8:  sval = {{56{acc_new[7]}},  acc_new[7:0]};
      TYPE_S16: sval = {{48{acc_new[15]}}, acc_new[15:0]};
      TYPE_S32: sval = {{32{acc_new[31]}}, acc_new[31:0]};
      default:  sval = acc_new;
    endcase
  end

  always_comb begin
    char_count_nxt  = char_count_r;
    held_type_nxt   = held_type_r;
    held_length_nxt = held_length_r;
    acc_nxt         = acc_r;
    high_nib_nxt    = high_nib_r;
    res_valid       = 1'b0;
    res.value       = '0;
    res.value_type  = cur_type;
    res.status      = STATUS_OK;
    res.last        = 1'b0;

    if (accept) begin
      if (start && field_type > TYPE_STRING) begin
        // bad type: report and stay at field start
        res_valid  = 1'b1;
        res.status = STATUS_BAD_TYPE;
        res.last   = 1'b1;
      end else begin
        held_type_nxt   = cur_type;
        held_length_nxt = cur_len;
        acc_nxt         = acc_base;
        if (!char_count_r[0]) begin
          high_nib_nxt   = nib;
          char_count_nxt = char_count_r + 9'd1;
        end else if (held_type_r == TYPE_STRING) begin
          res_valid      = 1'b1;
          res.value      = VALUE_W'(byte_val);
          res.last       = str_fin;
          char_count_nxt = str_fin ? 9'd0 : char_count_r + 9'd1;
        end else if (byte_idx[2:0] != last_byte_idx(held_type_r)) begin
          acc_nxt        = acc_new;
          char_count_nxt = char_count_r + 9'd1;
        end else begin
          res_valid      = 1'b1;
          res.value      = sval;
          res.last       = 1'b1;
          acc_nxt        = '0;
          char_count_nxt = 9'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r  <= '0;
      held_type_r   <= '0;
      held_length_r <= '0;
      acc_r         <= '0;
      high_nib_r    <= '0;
    end else begin
      char_count_r  <= char_count_nxt;
      held_type_r   <= held_type_nxt;
      held_length_r <= held_length_nxt;
      acc_r         <= acc_nxt;
      high_nib_r    <= high_nib_nxt;
    end
  end

endmodule

/* rtl/hafd_out_buf.sv */
// Result register with one skid entry, so input ready is registered.
module hafd_out_buf
  import hafd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  hafd_res_t res,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output hafd_res_t out_res
);

  logic      main_v_r, main_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  hafd_res_t main_r, main_nxt;
  hafd_res_t skid_r, skid_nxt;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r || out_ready) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else begin
        main_nxt   = res;
        main_v_nxt = res_valid;
      end
    end else if (res_valid) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign in_ready  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

endmodule

/* rtl/hex_ascii_field_decoder.sv */
// Top level of the hex ASCII field decoder.
//
// Input stream: one ASCII character per transaction. in_tdata carries the
// character and the string length, in_tuser the field type; type and length
// are only looked at on the first character of a field. Two characters make
// a byte, high nibble first; non-hex characters count as zero.
// Output stream: out_tdata is the 64-bit value (one byte for strings,
// little-endian for numerics and sign-extended for the signed types), out_tuser the type and
// status, out_tlast marks the result that completes a field.
// Throughput: one character per cycle while in_tready is high. A result is
// presented the cycle after its final character is taken, unless the receiver
// stalls. The result register plus one skid entry decouple the two sides;
// in_tready is registered and drops only once both entries hold results and
// the receiver stalls. Reset clears the field state and empties both entries.
module hex_ascii_field_decoder
  import hafd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // [7:0] hex_char, [15:8] string_length
  input  logic [3:0]         in_tuser,   // [3:0] field_type
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,  // [63:0] value
  output logic [USER_W-1:0]  out_tuser,  // [3:0] value_type, [4] status
  output logic               out_tlast   // last
);

  logic      accept;
  logic      res_valid;
  hafd_res_t res;
  hafd_res_t out_res;

  assign accept = in_tvalid && in_tready;

  hafd_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .hex_char      (in_tdata[7:0]),
    .field_type    (in_tuser),
    .string_length (in_tdata[15:8]),
    .res_valid     (res_valid),
    .res           (res)
  );

  hafd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = out_res.value;
  assign out_tuser = {out_res.status, out_res.value_type};
  assign out_tlast = out_res.last;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled while result register empty");

  a_bad_type_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[4] == STATUS_BAD_TYPE |->
      out_tlast && out_tdata == '0 && out_tuser[3:0] > TYPE_STRING)
    else $error("malformed invalid-type result");

  a_partial_only_string: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[3:0] == TYPE_STRING)
    else $error("non-final result for a numeric field");

  a_string_byte_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3:0] == TYPE_STRING |-> out_tdata[VALUE_W-1:8] == '0)
    else $error("string result wider than one byte");

endmodule

/* tb/hafd_tb_pkg.sv */
// Expected-result tracking for the hex ASCII field decoder testbench.
`timescale 1ns / 1ps

package hafd_tb_pkg;
  import hafd_pkg::*;

  class hex_field_predictor;
    // decoder state as seen from the character stream
    logic [8:0]  char_count;
    logic [3:0]  held_type;
    logic [7:0]  held_length;
    logic [63:0] acc;
    logic [3:0]  high_nib;

    hafd_res_t expected_results[$];
    int        failures;
    int        chars_taken;
    int        results_checked;
    int        bad_type_results;

    function new();
      char_count  = '0;
      held_type   = '0;
      held_length = '0;
      acc         = '0;
      high_nib    = '0;
      failures    = 0;
      chars_taken = 0;
      results_checked  = 0;
      bad_type_results = 0;
    endfunction

    static function logic [3:0] hex_digit_value(input logic [7:0] c);
      // '0'..'9' sit at 0x30, 'a'/'A' at 0x61/0x41, so the low nibble does most of the work
      if (c inside {["0":"9"]}) return c[3:0];
      if (c inside {["a":"f"], ["A":"F"]}) return c[3:0] + 4'd9;
      return 4'd0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // one accepted character; queues the result it causes, if any
    function void take_char(input logic [7:0] c, input logic [3:0] ft, input logic [7:0] len);
      logic [3:0]  nib;
      logic [7:0]  byte_v;
      logic [63:0] v;
      hafd_res_t   r;
      int          idx;
      int          nbytes;
      int          bits;

      chars_taken++;
      nib = hex_digit_value(c);
      if (char_count == 0) begin
        if (ft > TYPE_STRING) begin
          r.value      = '0;
          r.value_type = ft;
          r.status     = STATUS_BAD_TYPE;
          r.last       = 1'b1;
          expected_results.push_back(r);
          return;
        end
        held_type   = ft;
        held_length = (len == 8'd0) ? 8'd1 : len;
        acc         = '0;
      end

      if (!char_count[0]) begin
        high_nib = nib;
        char_count++;
        return;
      end

      byte_v = {high_nib, nib};
      idx    = int'(char_count >> 1);

      if (held_type == TYPE_STRING) begin
        r.value      = 64'(byte_v);
        r.value_type = held_type;
        r.status     = STATUS_OK;
        r.last       = (idx + 1 >= int'(held_length));
        expected_results.push_back(r);
        char_count = r.last ? 9'd0 : char_count + 9'd1;
        return;
      end

      case (held_type)
        TYPE_F32: nbytes = 4;
        TYPE_F64: nbytes = 8;
        default:  nbytes = 1 << held_type[1:0];
      endcase
      acc = acc | (64'(byte_v) << (8 * idx));
      if (idx + 1 < nbytes) begin
        char_count++;
        return;
      end

      v = acc;
      if (held_type >= TYPE_S8 && held_type <= TYPE_S64 && nbytes < 8) begin
        bits = 8 * nbytes;
        if (acc[bits-1]) v = acc | (~64'd0 << bits);
      end
      r.value      = v;
      r.value_type = held_type;
      r.status     = STATUS_OK;
      r.last       = 1'b1;
      expected_results.push_back(r);
      char_count = '0;
      acc        = '0;
    endfunction

    // one accepted result against the oldest expectation
    function void check_value(input logic [63:0] value, input logic [3:0] vtype,
                              input logic st, input logic lst);
      hafd_res_t e;

      if (expected_results.size() == 0) begin
        $error("unexpected result: value %h type %0d status %0d last %0d",
               value, vtype, st, lst);
        failures++;
        return;
      end
      e = expected_results.pop_front();
      results_checked++;
      if (e.status == STATUS_BAD_TYPE) bad_type_results++;
      if (value !== e.value) begin
        $error("value mismatch: expected %h, got %h", e.value, value);
        failures++;
      end
      if (vtype !== e.value_type) begin
        $error("value_type mismatch: expected %0d, got %0d", e.value_type, vtype);
        failures++;
      end
      if (st !== e.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, st);
        failures++;
      end
      if (lst !== e.last) begin
        $error("last mismatch: expected %0d, got %0d", e.last, lst);
        failures++;
      end
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench: drives hex characters into the decoder and checks every result.
`timescale 1ns / 1ps

module tb_top;
  import hafd_pkg::*;
  import hafd_tb_pkg::*;

  localparam logic [3:0] TYPE_BAD_LO = TYPE_STRING + 4'd1;
  localparam logic [3:0] TYPE_BAD_HI = 4'hF;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASE_CHARS    = 100;
  localparam int HOLD_CYCLES    = 120;
  localparam int LONG_STRING    = 64;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [15:0]        in_tdata;   // [7:0] hex_char, [15:8] string_length
  logic [3:0]         in_tuser;   // [3:0] field_type
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;  // [63:0] value
  logic [USER_W-1:0]  out_tuser;  // [3:0] value_type, [4] status
  logic               out_tlast;

  hex_field_predictor predictor;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  noise_pct;
  bit  recv_hold = 1'b0;
  int  cycle_count = 0;

  hex_ascii_field_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      predictor.check_value(out_tdata, out_tuser[3:0], out_tuser[4], out_tlast);

  // hex digit for a nibble, random case; sometimes any byte at all
  function automatic logic [7:0] char_for(input logic [3:0] n);
    if ($urandom_range(99) < noise_pct) return 8'($urandom_range(255));
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(1) ? "a" : "A") + n - 4'd10);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic [3:0] ft, input logic [7:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {len, c};
    in_tuser  <= ft;
    do @(posedge clk); while (!in_tready);
    predictor.take_char(c, ft, len);
  endtask

  // type and length only matter on the first character of a field
  task automatic send_pair(input logic [7:0] b, input bit first, input logic [3:0] ft,
                           input logic [7:0] len);
    send_char(char_for(b[7:4]), first ? ft : 4'($urandom_range(15)),
              first ? len : 8'($urandom_range(255)));
    send_char(char_for(b[3:0]), 4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  task automatic send_random_field();
    logic [3:0] ft;
    logic [7:0] len;
    int         nbytes;

    if ($urandom_range(99) < 8) begin
      send_char(8'($urandom_range(255)), 4'($urandom_range(TYPE_BAD_HI, TYPE_BAD_LO)),
                8'($urandom_range(255)));
      return;
    end
    ft  = 4'($urandom_range(TYPE_STRING));
    len = 8'($urandom_range(255));
    case (ft)
      TYPE_STRING: begin
        len    = ($urandom_range(19) == 0) ? 8'($urandom_range(40, 9)) : 8'($urandom_range(8, 1));
        nbytes = int'(len);
      end
      TYPE_F32: nbytes = 4;
      TYPE_F64: nbytes = 8;
      default:  nbytes = 1 << ft[1:0];
    endcase
    for (int i = 0; i < nbytes; i++)
      send_pair(8'($urandom_range(255)), i == 0, ft, len);
  endtask

  task automatic run_random(input int chars);
    int start;
    start = predictor.chars_taken;
    while (predictor.chars_taken - start < chars)
      send_random_field();
  endtask

  // stop offering and wait for every queued result
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (predictor.pending() != 0) @(posedge clk);
  endtask

  task automatic hold_receiver(input int cycles);
    recv_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    recv_hold = 1'b0;
  endtask

  initial begin
    predictor     = new();
    send_idle_pct = 22;
    recv_idle_pct = 82;
    noise_pct     = 0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: bad types, extremes, sign extension, string corner cases
    send_char("A", TYPE_BAD_HI, 8'd0);
    send_char(8'hFF, TYPE_BAD_LO, 8'hFF);
    send_pair(8'hFF, 1'b1, TYPE_U8, 8'hFF);
    send_pair(8'h80, 1'b1, TYPE_S8, 8'h00);
    send_pair(8'h7F, 1'b1, TYPE_S8, 8'h80);
    send_pair(8'h00, 1'b1, TYPE_S16, 8'h01);
    send_pair(8'h80, 1'b0, TYPE_S16, 8'h01);
    send_pair(8'h7a, 1'b1, TYPE_STRING, 8'd0);   // zero length acts as one
    send_char("z", TYPE_STRING, 8'd2);          // non-hex characters decode as zero
    send_char("Z", TYPE_BAD_HI, 8'd255);
    send_char(8'h00, TYPE_BAD_HI, 8'd0);
    send_char(8'hFF, TYPE_U8, 8'd7);
    send_pair(8'hAF, 1'b1, TYPE_U8, 8'd3);
    drain();

    noise_pct = 10;
    run_random(PHASE_CHARS);
    drain();

    send_idle_pct = 82;
    recv_idle_pct = 22;
    run_random(PHASE_CHARS);
    drain();

    // no idling; receiver blocked for a while so the input side backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      hold_receiver(HOLD_CYCLES);
    join_none
    run_random(PHASE_CHARS);
    for (int i = 0; i < LONG_STRING; i++)
      send_pair(8'($urandom_range(255)), i == 0, TYPE_STRING, 8'(LONG_STRING));
    drain();

    repeat (8) @(posedge clk);
    if (predictor.pending() != 0) begin
      $error("%0d results never arrived", predictor.pending());
      predictor.failures++;
    end
    $display("Run covered %0d characters and %0d results (%0d invalid-type), all field types,",
             predictor.chars_taken, predictor.results_checked, predictor.bad_type_results);
    $display("noise characters, a %0d-byte string and backpressure on both sides.",
             LONG_STRING);
    if (predictor.failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
